// File: hw/rtl/smsq_pkg.sv
`timescale 1ns / 1ps

package smsq_pkg;

	localparam int STEPS_DEFAULT = 8;

	localparam logic [1:0] OP_TICK    = 2'd0;
	localparam logic [1:0] OP_KEY_ON  = 2'd1;
	localparam logic [1:0] OP_KEY_OFF = 2'd2;
	localparam logic [1:0] OP_RSVD    = 2'd3;

	localparam logic EV_NOTE_ON  = 1'b0;
	localparam logic EV_NOTE_OFF = 1'b1;

	localparam logic [2:0] CFG_ENABLE         = 3'd0;
	localparam logic [2:0] CFG_PITCH_OFFSETS  = 3'd1;
	localparam logic [2:0] CFG_STEPS_USED     = 3'd2;
	localparam logic [2:0] CFG_PULSE_INTERVAL = 3'd3;
	localparam logic [2:0] CFG_GATE_LENGTH    = 3'd4;

	localparam logic [3:0]  RST_STEPS_USED     = 4'd8;
	localparam logic [19:0] RST_PULSE_INTERVAL = 20'd5512;
	localparam logic [19:0] RST_GATE_LENGTH    = 20'd2756;
	localparam logic [6:0]  RST_BASE_NOTE      = 7'd60;

	localparam logic [20:0] ELAPSED_MAX = 21'h1FFFFF;

	typedef struct packed {
		logic [1:0] kind;
		logic [6:0] note;
		logic [3:0] chan;
	} cmd_t;

endpackage

// File: hw/rtl/smsq_front.sv
`timescale 1ns / 1ps

module smsq_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  logic [15:0]       s_axis_tdata,  // key_note[6:0], key_channel[11:7], zero fill
	input  logic [1:0]        s_axis_tuser,  // operation[1:0]
	output logic              cmd_valid,
	input  logic              cmd_ready,
	output smsq_pkg::cmd_t    cmd
);

	localparam int QD     = 2;
	localparam int QPTR_W = $clog2(QD);
	localparam int QCNT_W = $clog2(QD + 1);

	smsq_pkg::cmd_t      queue_q [QD];
	logic [QPTR_W-1:0]   wptr_q;
	logic [QPTR_W-1:0]   rptr_q;
	logic [QCNT_W-1:0]   count_q;
	smsq_pkg::cmd_t      dec;
	logic                push;
	logic                pop;

	// classify: fold the channel to 0..15; push drops the reserved opcode
	always_comb begin
		dec.kind = s_axis_tuser;
		dec.note = s_axis_tdata[6:0];
		dec.chan = s_axis_tdata[10:7] - 4'd1;
	end

	assign s_axis_tready = (count_q != QCNT_W'(QD));
	assign push          = s_axis_tvalid && s_axis_tready && (s_axis_tuser != smsq_pkg::OP_RSVD);
	assign cmd_valid     = (count_q != '0);
	assign pop           = cmd_valid && cmd_ready;
	assign cmd           = queue_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == QPTR_W'(QD - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= (rptr_q == QPTR_W'(QD - 1)) ? '0 : rptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wptr_q] <= dec;
		end
	end

endmodule

// File: hw/rtl/smsq_back.sv
`timescale 1ns / 1ps

module smsq_back #(
	parameter int STEPS = smsq_pkg::STEPS_DEFAULT
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [2:0]        cfg_index,
	input  logic [63:0]       cfg_data,
	input  logic              cmd_valid,
	output logic              cmd_ready,
	input  smsq_pkg::cmd_t    cmd,
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	output logic [15:0]       m_axis_tdata,  // note[6:0], channel[11:7], zero fill
	output logic              m_axis_tuser,  // event_kind
	output logic              m_axis_tlast
);

	localparam int IDX_W = $clog2(STEPS);
	localparam int EXT_W = (IDX_W > 3) ? IDX_W : 3;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SCAN  = 2'd1;
	localparam logic [1:0] ST_FLUSH = 2'd2;

	logic        enable_q;
	logic [63:0] offsets_q;
	logic [3:0]  steps_used_q;
	logic [19:0] interval_q;
	logic [19:0] gate_len_q;

	logic [1:0]       state_q;
	logic             playing_q;
	logic [IDX_W-1:0] step_q;
	logic [IDX_W-1:0] scan_q;
	logic [19:0]      pulse_q;
	logic [6:0]       base_q;
	logic [3:0]       chan_q;

	logic        gate_armed_q   [STEPS];
	logic [6:0]  gate_note_q    [STEPS];
	logic [20:0] gate_elapsed_q [STEPS];

	logic       held_vld_q;
	logic       held_kind_q;
	logic [6:0] held_note_q;

	logic       out_vld_q;
	logic       out_kind_q;
	logic [6:0] out_note_q;
	logic [4:0] out_chan_q;
	logic       out_last_q;

	logic [4:0]       lim;
	logic [IDX_W-1:0] step_nxt;
	logic             wrap;
	logic [EXT_W-1:0] step_ext;
	logic [7:0]       off;
	logic signed [8:0] sum;
	logic [6:0]       note_on;
	logic             out_free;
	logic             tick_go;
	logic             arm_en;
	logic             expire;
	logic             stall;
	logic             scan_go;
	logic             out_load;
	logic             scan_end;

	assign cfg_ready = 1'b1;
	assign cmd_ready = (state_q == ST_IDLE);

	always_comb begin
		if (steps_used_q == 4'd0) begin
			lim = 5'd1;
		end else if ({1'b0, steps_used_q} > 5'(STEPS)) begin
			lim = 5'(STEPS);
		end else begin
			lim = {1'b0, steps_used_q};
		end
	end

	assign step_nxt = ((5'(step_q) + 5'd1) >= lim) ? '0 : step_q + 1'b1;
	assign wrap     = (({1'b0, pulse_q} + 21'd1) >= {1'b0, interval_q});
	assign step_ext = EXT_W'(step_q);
	assign off      = offsets_q[{step_ext[2:0], 3'b000} +: 8];
	assign sum      = $signed({2'b00, base_q}) + $signed({off[7], off});

	always_comb begin
		if (sum[8]) begin
			note_on = 7'd0;
		end else if (sum[7]) begin
			note_on = 7'd127;
		end else begin
			note_on = sum[6:0];
		end
	end

	assign out_free = !out_vld_q || m_axis_tready;
	assign tick_go  = (state_q == ST_IDLE) && cmd_valid && (cmd.kind == smsq_pkg::OP_TICK)
		&& enable_q;
	assign arm_en   = tick_go && playing_q && wrap;
	assign expire   = gate_armed_q[scan_q] && (gate_elapsed_q[scan_q] > {1'b0, gate_len_q});
	assign stall    = expire && held_vld_q && !out_free;
	assign scan_go  = (state_q == ST_SCAN) && !stall;
	assign scan_end = (scan_q == IDX_W'(STEPS - 1));
	assign out_load = (scan_go && expire && held_vld_q)
		|| ((state_q == ST_FLUSH) && held_vld_q && out_free);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q     <= 1'b0;
			offsets_q    <= '0;
			steps_used_q <= smsq_pkg::RST_STEPS_USED;
			interval_q   <= smsq_pkg::RST_PULSE_INTERVAL;
			gate_len_q   <= smsq_pkg::RST_GATE_LENGTH;
			state_q      <= ST_IDLE;
			playing_q    <= 1'b0;
			step_q       <= '0;
			scan_q       <= '0;
			pulse_q      <= '0;
			base_q       <= smsq_pkg::RST_BASE_NOTE;
			chan_q       <= '0;
			held_vld_q   <= 1'b0;
			out_vld_q    <= 1'b0;
			for (int i = 0; i < STEPS; i++) begin
				gate_armed_q[i] <= 1'b0;
			end
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					smsq_pkg::CFG_ENABLE:         enable_q     <= cfg_data[0];
					smsq_pkg::CFG_PITCH_OFFSETS:  offsets_q    <= cfg_data;
					smsq_pkg::CFG_STEPS_USED:     steps_used_q <= cfg_data[3:0];
					smsq_pkg::CFG_PULSE_INTERVAL: interval_q   <= cfg_data[19:0];
					smsq_pkg::CFG_GATE_LENGTH:    gate_len_q   <= cfg_data[19:0];
					default: ;
				endcase
			end

			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_vld_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						case (cmd.kind)
							smsq_pkg::OP_KEY_ON: begin
								base_q    <= cmd.note;
								chan_q    <= cmd.chan;
								step_q    <= '0;
								pulse_q   <= '0;
								playing_q <= 1'b1;
							end
							smsq_pkg::OP_KEY_OFF: begin
								playing_q <= 1'b0;
							end
							smsq_pkg::OP_TICK: begin
								if (enable_q) begin
									if (playing_q) begin
										if (wrap) begin
											pulse_q              <= '0;
											gate_armed_q[step_q] <= 1'b1;
											held_vld_q           <= 1'b1;
											step_q               <= step_nxt;
										end else begin
											pulse_q <= pulse_q + 20'd1;
										end
									end
									scan_q  <= '0;
									state_q <= ST_SCAN;
								end
							end
							default: ;
						endcase
					end
				end
				ST_SCAN: begin
					if (scan_go) begin
						if (expire) begin
							gate_armed_q[scan_q] <= 1'b0;
							held_vld_q           <= 1'b1;
						end
						if (scan_end) begin
							state_q <= ST_FLUSH;
						end else begin
							scan_q <= scan_q + 1'b1;
						end
					end
				end
				ST_FLUSH: begin
					if (!held_vld_q) begin
						state_q <= ST_IDLE;
					end else if (out_free) begin
						held_vld_q <= 1'b0;
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (arm_en) begin
			gate_note_q[step_q]    <= note_on;
			gate_elapsed_q[step_q] <= '0;
			held_kind_q            <= smsq_pkg::EV_NOTE_ON;
			held_note_q            <= note_on;
		end
		if (scan_go) begin
			if (expire) begin
				held_kind_q <= smsq_pkg::EV_NOTE_OFF;
				held_note_q <= gate_note_q[scan_q];
			end else if (gate_armed_q[scan_q]
				&& (gate_elapsed_q[scan_q] != smsq_pkg::ELAPSED_MAX)) begin
				gate_elapsed_q[scan_q] <= gate_elapsed_q[scan_q] + 21'd1;
			end
		end
		if (out_load) begin
			out_kind_q <= held_kind_q;
			out_note_q <= held_note_q;
			out_chan_q <= {1'b0, chan_q} + 5'd1;
			out_last_q <= (state_q == ST_FLUSH);
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {4'b0000, out_chan_q, out_note_q};
	assign m_axis_tuser  = out_kind_q;
	assign m_axis_tlast  = out_last_q;

	a_idle_no_held: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !held_vld_q)
		else $error("pending event left behind at end of tick");

	a_scan_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (scan_q <= IDX_W'(STEPS - 1)))
		else $error("gate scan index out of range");

	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		step_q <= IDX_W'(STEPS - 1))
		else $error("step index out of range");

	a_flush_last: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_FLUSH) && held_vld_q && out_free) |=> (out_vld_q && out_last_q))
		else $error("final event of a tick not marked last");

endmodule

// File: hw/rtl/midi_step_sequencer_top.sv
`timescale 1ns / 1ps

// Step sequencer for MIDI note events.
// Input stream (s_axis_*): one beat per command; tuser carries the operation
// (sample tick, key note-on, key note-off), tdata the key note and channel.
// Output stream (m_axis_*): one beat per note event; tuser is the event kind
// (0 note-on, 1 note-off), tdata note and channel, tlast marks the final event
// of a tick. Key commands and ticks that cause nothing produce no beat.
// Configuration channel (cfg_*): write register cfg_index with cfg_data;
// always ready, write only while the sequencer is quiet.
// Timing: commands enter a two-beat queue. The executor handles an enabled tick
// as a pulse step in the idle state, a release scan over every gate, then a
// flush state; key commands and disabled ticks are handled in the idle state.
// Each event waits in a one-beat holding register until the next event is
// found or the scan ends; up to STEPS events leave at one per cycle at most,
// while the receiver keeps up, the last one loaded in the flush state.
// Reset: all gates idle, playback stopped, registers at their defaults.
// When the receiver stalls, the executor holds its scan and the queue fills;
// s_axis_tready drops once two commands are waiting.

module midi_step_sequencer_top #(
	parameter int STEPS = smsq_pkg::STEPS_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // key_note[6:0], key_channel[11:7], zero fill
	input  logic [1:0]  s_axis_tuser,  // operation[1:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,  // note[6:0], channel[11:7], zero fill
	output logic        m_axis_tuser,  // event_kind
	output logic        m_axis_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data
);

	logic           cmd_valid;
	logic           cmd_ready;
	smsq_pkg::cmd_t cmd;

	smsq_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.cmd_valid     (cmd_valid),
		.cmd_ready     (cmd_ready),
		.cmd           (cmd)
	);

	smsq_back #(
		.STEPS (STEPS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.cmd_valid     (cmd_valid),
		.cmd_ready     (cmd_ready),
		.cmd           (cmd),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule

// File: sim/midi_step_sequencer_top_tb.sv
`timescale 1ns / 1ps

module midi_step_sequencer_top_tb;

	localparam int          STEPS       = smsq_pkg::STEPS_DEFAULT;
	localparam int          SETTLE      = 48;
	localparam int          HOLD_CYCLES = 300;
	localparam logic [2:0]  CFG_SPARE_5 = 3'd5;
	localparam logic [2:0]  CFG_SPARE_7 = 3'd7;

	typedef struct packed {
		logic       kind;
		logic [6:0] note;
		logic [4:0] chan;
		logic       last;
	} note_ev_t;

	typedef struct packed {
		logic        is_cfg;
		logic [2:0]  reg_idx;
		logic [63:0] reg_val;
		logic [1:0]  op;
		logic [6:0]  kn;
		logic [4:0]  kc;
		logic        typed;
		logic        has_ev;
		note_ev_t    ev;
	} dir_row_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata;
	logic [1:0]  s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;
	logic        m_axis_tuser;
	logic        m_axis_tlast;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [63:0] cfg_data;

	midi_step_sequencer_top #(
		.STEPS(STEPS)
	) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #5 clk = ~clk;

	// sequencer shadow state
	logic        en_r;
	logic [63:0] offs_r;
	logic [3:0]  steps_r;
	logic [19:0] ival_r;
	logic [19:0] gate_r;
	logic        playing_r;
	logic [2:0]  step_r;
	logic [19:0] pulse_r;
	logic [6:0]  base_r;
	logic [3:0]  chan_r;
	logic        armed_r   [STEPS];
	logic [6:0]  gnote_r   [STEPS];
	logic [20:0] gelapsed_r[STEPS];

	note_ev_t step_events[$];
	note_ev_t pending_notes[$];

	int src_idle_pct;
	int sink_idle_pct;
	int hold_left = 0;
	bit hold_req  = 1'b0;
	bit hold_done = 1'b0;
	int mismatches = 0;
	int cmds_sent;
	int cmds_directed;
	int cfg_writes;
	int ons_seen  = 0;
	int offs_seen = 0;

	note_ev_t got;
	note_ev_t want;

	task automatic seq_reset();
		en_r      = 1'b0;
		offs_r    = '0;
		steps_r   = smsq_pkg::RST_STEPS_USED;
		ival_r    = smsq_pkg::RST_PULSE_INTERVAL;
		gate_r    = smsq_pkg::RST_GATE_LENGTH;
		playing_r = 1'b0;
		step_r    = '0;
		pulse_r   = '0;
		base_r    = smsq_pkg::RST_BASE_NOTE;
		chan_r    = '0;
		for (int i = 0; i < STEPS; i++) begin
			armed_r[i]    = 1'b0;
			gnote_r[i]    = '0;
			gelapsed_r[i] = '0;
		end
	endtask

	task automatic seq_write(input logic [2:0] idx, input logic [63:0] val);
		case (idx)
			smsq_pkg::CFG_ENABLE:         en_r    = val[0];
			smsq_pkg::CFG_PITCH_OFFSETS:  offs_r  = val;
			smsq_pkg::CFG_STEPS_USED:     steps_r = val[3:0];
			smsq_pkg::CFG_PULSE_INTERVAL: ival_r  = val[19:0];
			smsq_pkg::CFG_GATE_LENGTH:    gate_r  = val[19:0];
			default: ;
		endcase
	endtask

	// fill step_events with the note events one command causes
	task automatic seq_advance(input logic [1:0] op, input logic [6:0] kn,
			input logic [4:0] kc);
		int unsigned        nxt;
		int unsigned        lim;
		int                 idx;
		int                 nv;
		logic signed [7:0]  off;
		note_ev_t           ev;
		step_events.delete();
		if (op == smsq_pkg::OP_KEY_ON) begin
			base_r    = kn;
			chan_r    = kc[3:0] - 4'd1;
			step_r    = '0;
			pulse_r   = '0;
			playing_r = 1'b1;
		end else if (op == smsq_pkg::OP_KEY_OFF) begin
			playing_r = 1'b0;
		end else if (op == smsq_pkg::OP_TICK && en_r) begin
			if (playing_r) begin
				nxt = pulse_r + 1;
				if (nxt >= ival_r) begin
					idx = step_r;
					off = offs_r[(idx % 8) * 8 +: 8];
					nv  = int'(base_r) + int'(off);
					if (nv < 0)
						nv = 0;
					if (nv > 127)
						nv = 127;
					pulse_r         = '0;
					gnote_r[idx]    = nv[6:0];
					armed_r[idx]    = 1'b1;
					gelapsed_r[idx] = '0;
					ev.kind = smsq_pkg::EV_NOTE_ON;
					ev.note = nv[6:0];
					ev.chan = {1'b0, chan_r} + 5'd1;
					ev.last = 1'b0;
					step_events.push_back(ev);
					lim = steps_r;
					if (lim == 0)
						lim = 1;
					if (lim > STEPS)
						lim = STEPS;
					idx++;
					if (idx >= lim)
						idx = 0;
					step_r = idx[2:0];
				end else begin
					pulse_r = nxt[19:0];
				end
			end
			for (int i = 0; i < STEPS; i++) begin
				if (armed_r[i]) begin
					if (gelapsed_r[i] > {1'b0, gate_r}) begin
						ev.kind = smsq_pkg::EV_NOTE_OFF;
						ev.note = gnote_r[i];
						ev.chan = {1'b0, chan_r} + 5'd1;
						ev.last = 1'b0;
						step_events.push_back(ev);
						armed_r[i] = 1'b0;
					end else if (gelapsed_r[i] < smsq_pkg::ELAPSED_MAX) begin
						gelapsed_r[i] = gelapsed_r[i] + 21'd1;
					end
				end
			end
			if (step_events.size() > 0) begin
				ev = step_events[step_events.size() - 1];
				ev.last = 1'b1;
				step_events[step_events.size() - 1] = ev;
			end
		end
	endtask

	// called at a falling edge; returns at the falling edge after the beat
	task automatic send_cmd(input logic [1:0] op, input logic [6:0] kn, input logic [4:0] kc,
			input logic typed, input logic has_ev, input note_ev_t ev);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= op;
		s_axis_tdata  <= {4'h0, kc, kn};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		seq_advance(op, kn, kc);
		if (typed) begin
			if (has_ev)
				pending_notes.push_back(ev);
		end else begin
			foreach (step_events[i])
				pending_notes.push_back(step_events[i]);
		end
		cmds_sent++;
		@(negedge clk);
	endtask

	task automatic cfg_write(input logic [2:0] idx, input logic [63:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		seq_write(idx, val);
		cfg_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	// drop valid, drain every expected event, then let the executor settle
	task automatic wait_quiet();
		s_axis_tvalid <= 1'b0;
		while (pending_notes.size() != 0)
			@(negedge clk);
		repeat (SETTLE)
			@(negedge clk);
	endtask

	task automatic shuffle_config(input bit busy);
		logic [63:0] v;
		v = {$urandom, $urandom};
		v[0] = busy ? 1'b1 : ($urandom_range(0, 9) != 0);
		cfg_write(smsq_pkg::CFG_ENABLE, v);
		cfg_write(smsq_pkg::CFG_PITCH_OFFSETS, {$urandom, $urandom});
		v = {$urandom, $urandom};
		v[3:0] = 4'($urandom_range(0, 15));
		cfg_write(smsq_pkg::CFG_STEPS_USED, v);
		v = {$urandom, $urandom};
		if (busy)
			v[19:0] = 20'($urandom_range(0, 2));
		else if ($urandom_range(0, 9) < 8)
			v[19:0] = 20'($urandom_range(0, 5));
		cfg_write(smsq_pkg::CFG_PULSE_INTERVAL, v);
		v = {$urandom, $urandom};
		if (busy)
			v[19:0] = 20'($urandom_range(0, 3));
		else if ($urandom_range(0, 9) < 8)
			v[19:0] = 20'($urandom_range(0, 10));
		cfg_write(smsq_pkg::CFG_GATE_LENGTH, v);
	endtask

	function automatic dir_row_t cfg_row(input logic [2:0] idx, input logic [63:0] val);
		dir_row_t r;
		r = '0;
		r.is_cfg  = 1'b1;
		r.reg_idx = idx;
		r.reg_val = val;
		return r;
	endfunction

	function automatic dir_row_t cmd_row(input logic [1:0] op, input logic [6:0] kn,
			input logic [4:0] kc, input logic typed);
		dir_row_t r;
		r = '0;
		r.op    = op;
		r.kn    = kn;
		r.kc    = kc;
		r.typed = typed;
		return r;
	endfunction

	// output side: ready pattern and long hold-off
	always @(negedge clk) begin
		if (hold_req && !hold_done) begin
			hold_left = HOLD_CYCLES;
			hold_done = 1'b1;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = {m_axis_tuser, m_axis_tdata[6:0], m_axis_tdata[11:7], m_axis_tlast};
			if (got.kind == smsq_pkg::EV_NOTE_ON)
				ons_seen++;
			else
				offs_seen++;
			if (pending_notes.size() == 0) begin
				if (mismatches < 10)
					$display("unexpected event: kind %0d note %0d ch %0d last %0d",
						got.kind, got.note, got.chan, got.last);
				mismatches++;
			end else begin
				want = pending_notes.pop_front();
				if (got !== want || m_axis_tdata[15:12] !== 4'd0) begin
					if (mismatches < 10)
						$display({"mismatch: expected kind %0d note %0d ch %0d last %0d, ",
							"got kind %0d note %0d ch %0d last %0d fill %h"},
							want.kind, want.note, want.chan, want.last,
							got.kind, got.note, got.chan, got.last,
							m_axis_tdata[15:12]);
					mismatches++;
				end
			end
		end
	end

	initial begin
		#5_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		dir_row_t  rows[$];
		dir_row_t  r;
		note_ev_t  blank;
		int        pick;
		logic [1:0] op;

		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = smsq_pkg::OP_TICK;
		cfg_valid     = 1'b0;
		cfg_index     = smsq_pkg::CFG_ENABLE;
		cfg_data      = '0;
		cmds_sent     = 0;
		cfg_writes    = 0;
		blank         = '0;
		src_idle_pct  = 26;
		sink_idle_pct = 61;
		seq_reset();

		// after reset the sequencer is disabled
		rows.push_back(cmd_row(smsq_pkg::OP_TICK, 7'd0, 5'd0, 1'b1));
		rows.push_back(cmd_row(smsq_pkg::OP_KEY_ON, 7'd60, 5'd1, 1'b1));
		rows.push_back(cmd_row(smsq_pkg::OP_TICK, 7'h7F, 5'h1F, 1'b1));
		rows.push_back(cmd_row(smsq_pkg::OP_RSVD, 7'h55, 5'h0A, 1'b1));
		rows.push_back(cfg_row(smsq_pkg::CFG_ENABLE, 64'h1));
		rows.push_back(cfg_row(smsq_pkg::CFG_PITCH_OFFSETS, 64'h1122_33FB_0500_807F));
		rows.push_back(cfg_row(smsq_pkg::CFG_PULSE_INTERVAL, 64'h1));
		rows.push_back(cfg_row(smsq_pkg::CFG_GATE_LENGTH, 64'h0));
		rows.push_back(cfg_row(smsq_pkg::CFG_STEPS_USED, 64'hFFFF_FFFF_FFFF_FFF9));
		rows.push_back(cfg_row(CFG_SPARE_5, 64'hFFFF_FFFF_FFFF_FFFF));
		rows.push_back(cfg_row(CFG_SPARE_7, 64'h0));
		// channel 0 maps to 16; first step clamps high
		rows.push_back(cmd_row(smsq_pkg::OP_KEY_ON, 7'd64, 5'd0, 1'b1));
		r = cmd_row(smsq_pkg::OP_TICK, 7'd0, 5'd0, 1'b1);
		r.has_ev = 1'b1;
		r.ev     = '{kind: smsq_pkg::EV_NOTE_ON, note: 7'd127, chan: 5'd16, last: 1'b1};
		rows.push_back(r);
		repeat (4)
			rows.push_back(cmd_row(smsq_pkg::OP_TICK, 7'd0, 5'd0, 1'b0));
		// key-off: playback stops, pending releases still go out
		rows.push_back(cmd_row(smsq_pkg::OP_KEY_OFF, 7'd3, 5'd3, 1'b1));
		rows.push_back(cmd_row(smsq_pkg::OP_TICK, 7'd0, 5'd0, 1'b0));
		rows.push_back(cmd_row(smsq_pkg::OP_TICK, 7'd0, 5'd0, 1'b0));
		rows.push_back(cmd_row(smsq_pkg::OP_KEY_ON, 7'd127, 5'd31, 1'b1));
		rows.push_back(cmd_row(smsq_pkg::OP_TICK, 7'd0, 5'd0, 1'b0));
		rows.push_back(cmd_row(smsq_pkg::OP_TICK, 7'd0, 5'd0, 1'b0));
		rows.push_back(cfg_row(smsq_pkg::CFG_ENABLE, 64'hFFFF_FFFF_FFFF_FFFE));
		rows.push_back(cmd_row(smsq_pkg::OP_TICK, 7'd0, 5'd0, 1'b1));
		rows.push_back(cfg_row(smsq_pkg::CFG_ENABLE, 64'h1));
		// one step, zero interval, retrigger of a held gate
		rows.push_back(cfg_row(smsq_pkg::CFG_STEPS_USED, 64'h0));
		rows.push_back(cfg_row(smsq_pkg::CFG_PULSE_INTERVAL, 64'h0));
		rows.push_back(cfg_row(smsq_pkg::CFG_GATE_LENGTH, 64'h2));
		rows.push_back(cmd_row(smsq_pkg::OP_KEY_ON, 7'd0, 5'd17, 1'b1));
		repeat (4)
			rows.push_back(cmd_row(smsq_pkg::OP_TICK, 7'd0, 5'd0, 1'b0));
		rows.push_back(cfg_row(smsq_pkg::CFG_STEPS_USED, 64'hF));
		rows.push_back(cfg_row(smsq_pkg::CFG_PULSE_INTERVAL, 64'hF_FFFF));
		rows.push_back(cfg_row(smsq_pkg::CFG_GATE_LENGTH, 64'hF_FFFF));
		rows.push_back(cmd_row(smsq_pkg::OP_TICK, 7'd0, 5'd0, 1'b0));
		rows.push_back(cmd_row(smsq_pkg::OP_KEY_ON, 7'd1, 5'd16, 1'b1));
		rows.push_back(cmd_row(smsq_pkg::OP_TICK, 7'd0, 5'd0, 1'b0));
		rows.push_back(cmd_row(smsq_pkg::OP_TICK, 7'd0, 5'd0, 1'b0));

		repeat (9)
			@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (rows[i]) begin
			if (rows[i].is_cfg) begin
				wait_quiet();
				cfg_write(rows[i].reg_idx, rows[i].reg_val);
			end else begin
				send_cmd(rows[i].op, rows[i].kn, rows[i].kc,
					rows[i].typed, rows[i].has_ev, rows[i].ev);
			end
		end
		cmds_directed = cmds_sent;

		for (int ph = 0; ph < 3; ph++) begin
			case (ph)
				0: begin
					src_idle_pct  = 26;
					sink_idle_pct = 61;
				end
				1: begin
					src_idle_pct  = 61;
					sink_idle_pct = 26;
				end
				default: begin
					src_idle_pct  = 0;
					sink_idle_pct = 0;
				end
			endcase
			for (int seg = 0; seg < 3; seg++) begin
				wait_quiet();
				shuffle_config(ph == 0 && seg == 1);
				if (ph == 0 && seg == 1)
					hold_req = 1'b1;
				send_cmd(smsq_pkg::OP_KEY_ON, 7'($urandom), 5'($urandom),
					1'b0, 1'b0, blank);
				for (int k = 0; k < 16; k++) begin
					pick = $urandom_range(0, 99);
					if (pick < 7)
						op = smsq_pkg::OP_KEY_ON;
					else if (pick < 12)
						op = smsq_pkg::OP_KEY_OFF;
					else if (pick < 15)
						op = smsq_pkg::OP_RSVD;
					else
						op = smsq_pkg::OP_TICK;
					send_cmd(op, 7'($urandom), 5'($urandom), 1'b0, 1'b0, blank);
				end
			end
		end

		wait_quiet();

		$display("Ran %0d commands (%0d directed) across %0d register writes;",
			cmds_sent, cmds_directed, cfg_writes);
		$display("saw %0d note-on and %0d note-off events.", ons_seen, offs_seen);
		$display({"Covered zero and full-scale intervals and gates, step counts 0 to 15, ",
			"clamping, retrigger and a long output stall."});
		if (mismatches == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

// File: midi_step_sequencer_top.f
hw/rtl/smsq_pkg.sv
hw/rtl/smsq_front.sv
hw/rtl/smsq_back.sv
hw/rtl/midi_step_sequencer_top.sv
sim/midi_step_sequencer_top_tb.sv
